// ===== sv/kvmm_pkg.sv =====
`default_nettype none
package kvmm_pkg;

    localparam int DEF_MAX_VECTOR_LENGTH = 256;
    localparam int DEF_MAX_BLOCK_TOKENS  = 128;

    localparam int ELEM_W   = 16;
    localparam int VLEN_W   = 9;
    localparam int TPB_W    = 8;
    localparam int DIMIDX_W = 8;
    localparam int METAROW_W = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    // wide enough for any limit up to 1024 plus one
    localparam int CMP_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOKENS_PER_BLOCK = 8'd1;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 9'd128;
    localparam logic [TPB_W-1:0]  TPB_RESET  = 8'd128;

    typedef struct packed {
        logic first;
        logic closing;
        logic last_dim;
        logic req_end;
    } ctl_t;

    // Map a half pattern onto an unsigned order; both zeros share one key.
    function automatic logic [ELEM_W-1:0] half_key(input logic [ELEM_W-1:0] h);
        logic [ELEM_W-1:0] k;
        if (h[ELEM_W-2:0] == '0)
        begin
            k = 16'h8000;
        end
        else if (h[ELEM_W-1])
        begin
            k = ~h;
        end
        else
        begin
            k = h | 16'h8000;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/kvmm_if.sv =====
`default_nettype none
interface kvmm_in_if;
    import kvmm_pkg::*;
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element_value;
    logic              request_end;
    modport source (output valid, element_value, request_end, input ready);
    modport sink   (input valid, element_value, request_end, output ready);
endinterface

interface kvmm_out_if;
    import kvmm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ELEM_W-1:0]    max_value;
    logic [ELEM_W-1:0]    min_value;
    logic [DIMIDX_W-1:0]  dim_index;
    logic [METAROW_W-1:0] meta_row;
    logic                 block_done;
    logic                 request_done;
    modport source (output valid, max_value, min_value, dim_index, meta_row, block_done,
                    request_done, input ready);
    modport sink   (input valid, max_value, min_value, dim_index, meta_row, block_done,
                    request_done, output ready);
endinterface

interface kvmm_cfg_if;
    import kvmm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/kv_block_minmax_reducer.sv =====
`default_nettype none
// Per-dimension fp16 max/min over key blocks. Feed one key element per request,
// row after row; every element of a block's closing row (its tokens_per_block-th
// row, or the row flagged request_end) returns one result with the dimension's
// final max and min, its index and the block's row in the metadata group. The
// block takes one element per cycle while the output is not stalled, and a
// result passes from the stage 1 register into the output register; the
// running-value RAM is read at accept and written back when stage 1 commits,
// with a bypass when the same dimension follows at once. While a result waits,
// the input stalls once stage 1 is full. Write vector_length (index 0) and
// tokens_per_block (index 1) only while idle; the running values need no
// clearing, since a block's first row loads them.
module kv_block_minmax_reducer
    import kvmm_pkg::*;
#(
    parameter int MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
    parameter int MAX_BLOCK_TOKENS  = DEF_MAX_BLOCK_TOKENS
)
(
    input wire logic clk,
    input wire logic rst_n,
    kvmm_in_if.sink     in_ch,
    kvmm_out_if.source  out_ch,
    kvmm_cfg_if.sink    cfg_ch
);

    localparam int DW = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
    localparam int TW = (MAX_BLOCK_TOKENS > 1) ? $clog2(MAX_BLOCK_TOKENS) : 1;

    // configuration registers
    logic [VLEN_W-1:0] vlen_reg;
    logic [TPB_W-1:0]  tpb_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_RESET;
            tpb_reg  <= TPB_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_VECTOR_LENGTH:    vlen_reg <= cfg_ch.data[VLEN_W-1:0];
                REG_TOKENS_PER_BLOCK: tpb_reg  <= cfg_ch.data[TPB_W-1:0];
                default:              ;
            endcase
        end
    end

    // pipeline control: stage 1 moves on whenever the output register is free
    logic s1_valid_reg;
    logic adv;
    logic accept;

    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || adv;
    assign accept      = in_ch.valid && in_ch.ready;

    // position counters
    logic [DW-1:0] dim;
    logic [TW-1:0] block;
    ctl_t          ctl;

    kvmm_seq #(
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .MAX_BLOCK_TOKENS  (MAX_BLOCK_TOKENS)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (accept),
        .request_end      (in_ch.request_end),
        .vector_length    (vlen_reg),
        .tokens_per_block (tpb_reg),
        .dim              (dim),
        .block            (block),
        .ctl              (ctl)
    );

    // stage 1 holding registers
    logic [ELEM_W-1:0] s1_val_reg;
    logic [DW-1:0]     s1_dim_reg;
    logic [TW-1:0]     s1_blk_reg;
    ctl_t              s1_ctl_reg;
    logic              hit_reg;
    logic [ELEM_W-1:0] fwd_max_reg, fwd_min_reg;

    logic              s1_commit;
    logic [2*ELEM_W-1:0] rd_data;
    logic [ELEM_W-1:0] cur_max, cur_min, new_max, new_min;

    assign s1_commit = s1_valid_reg && adv;

    kvmm_ram #(
        .DEPTH (MAX_VECTOR_LENGTH),
        .WIDTH (2 * ELEM_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s1_commit),
        .wr_addr (s1_dim_reg),
        .wr_data ({new_max, new_min}),
        .rd_en   (accept),
        .rd_addr (dim),
        .rd_data (rd_data)
    );

    // merge the element into the running values; bypass a same-cycle write
    always_comb
    begin
        cur_max = hit_reg ? fwd_max_reg : rd_data[2*ELEM_W-1:ELEM_W];
        cur_min = hit_reg ? fwd_min_reg : rd_data[ELEM_W-1:0];
        if (s1_ctl_reg.first)
        begin
            new_max = s1_val_reg;
            new_min = s1_val_reg;
        end
        else
        begin
            new_max = (half_key(s1_val_reg) > half_key(cur_max)) ? s1_val_reg : cur_max;
            new_min = (half_key(s1_val_reg) < half_key(cur_min)) ? s1_val_reg : cur_min;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                hit_reg      <= s1_commit && (s1_dim_reg == dim);
            end
            else if (s1_commit)
            begin
                s1_valid_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_val_reg  <= in_ch.element_value;
            s1_dim_reg  <= dim;
            s1_blk_reg  <= block;
            s1_ctl_reg  <= ctl;
            fwd_max_reg <= new_max;
            fwd_min_reg <= new_min;
        end
    end

    // output register: load a result for every element of a closing row
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_ctl_reg.closing;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_commit && s1_ctl_reg.closing)
        begin
            out_ch.max_value    <= new_max;
            out_ch.min_value    <= new_min;
            out_ch.dim_index    <= DIMIDX_W'(s1_dim_reg);
            out_ch.meta_row     <= METAROW_W'(s1_blk_reg);
            out_ch.block_done   <= s1_ctl_reg.last_dim;
            out_ch.request_done <= s1_ctl_reg.last_dim && s1_ctl_reg.req_end;
        end
    end

    assign out_ch.valid = out_valid_reg;

`ifndef SYNTH
    a_hit_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> s1_valid_reg)
        else $error("bypass flag set with empty stage");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && s1_valid_reg && !adv))
        else $error("request accepted over a stalled stage");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("pending result dropped");

    a_req_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.request_done) |-> out_ch.block_done)
        else $error("request end without block end");
`endif

endmodule
`default_nettype wire

// ===== sv/kvmm_seq.sv =====
`default_nettype none
module kvmm_seq
    import kvmm_pkg::*;
#(
    parameter int MAX_VECTOR_LENGTH = DEF_MAX_VECTOR_LENGTH,
    parameter int MAX_BLOCK_TOKENS  = DEF_MAX_BLOCK_TOKENS,
    localparam int DW = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1,
    localparam int TW = (MAX_BLOCK_TOKENS > 1) ? $clog2(MAX_BLOCK_TOKENS) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              request_end,
    input  wire logic [VLEN_W-1:0] vector_length,
    input  wire logic [TPB_W-1:0]  tokens_per_block,
    output logic      [DW-1:0]     dim,
    output logic      [TW-1:0]     block,
    output ctl_t                   ctl
);

    localparam logic [CMP_W-1:0] MAXV = CMP_W'(MAX_VECTOR_LENGTH);
    localparam logic [CMP_W-1:0] MAXB = CMP_W'(MAX_BLOCK_TOKENS);

    logic [DW-1:0] dim_reg, dim_next;
    logic [TW-1:0] tok_reg, tok_next;
    logic [TW-1:0] blk_reg, blk_next;
    logic [CMP_W-1:0] vl_raw, tpb_raw, eff_len, eff_tok;
    logic blk_wrap;

    always_comb
    begin
        vl_raw  = CMP_W'(vector_length);
        tpb_raw = CMP_W'(tokens_per_block);
        eff_len = (vl_raw == '0) ? CMP_W'(1) : ((vl_raw > MAXV) ? MAXV : vl_raw);
        eff_tok = (tpb_raw == '0) ? CMP_W'(1) : ((tpb_raw > MAXB) ? MAXB : tpb_raw);

        ctl.first    = (tok_reg == '0);
        ctl.last_dim = (CMP_W'(dim_reg) + CMP_W'(1)) >= eff_len;
        ctl.closing  = request_end || ((CMP_W'(tok_reg) + CMP_W'(1)) >= eff_tok);
        ctl.req_end  = request_end;
        blk_wrap     = request_end || ((CMP_W'(blk_reg) + CMP_W'(1)) >= eff_tok);

        dim_next = dim_reg;
        tok_next = tok_reg;
        blk_next = blk_reg;
        if (ctl.last_dim)
        begin
            dim_next = '0;
            if (ctl.closing)
            begin
                tok_next = '0;
                blk_next = blk_wrap ? '0 : blk_reg + TW'(1);
            end
            else
            begin
                tok_next = tok_reg + TW'(1);
            end
        end
        else
        begin
            dim_next = dim_reg + DW'(1);
        end
    end

    assign dim   = dim_reg;
    assign block = blk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= '0;
            tok_reg <= '0;
            blk_reg <= '0;
        end
        else if (advance)
        begin
            dim_reg <= dim_next;
            tok_reg <= tok_next;
            blk_reg <= blk_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/kvmm_ram.sv =====
`default_nettype none
module kvmm_ram
    import kvmm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_VECTOR_LENGTH,
    parameter int WIDTH = 2 * ELEM_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire
